@@ rtl/slt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tokeniser package
// Shared widths, token kind codes and the structures that pass between the
// scanner, the result queue and the channel interfaces.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 5;
    localparam int COUNT_W  = 16;

    // Default number of word characters kept for keyword matching.
    localparam int SLT_MAX_KEYWORD_LEN = 8;

    // Result queue depth; a power of two of at least two.
    localparam int SLT_QUEUE_DEPTH = 4;

    // Token kinds. Keywords take the codes 0 to 6 in table order.
    localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd7;
    localparam logic [KIND_W-1:0] KIND_INT    = 5'd8;
    localparam logic [KIND_W-1:0] KIND_STRING = 5'd9;
    localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd10;
    localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd11;
    localparam logic [KIND_W-1:0] KIND_STAR   = 5'd12;
    localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd13;
    localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd14;
    localparam logic [KIND_W-1:0] KIND_EQ     = 5'd15;
    localparam logic [KIND_W-1:0] KIND_NE     = 5'd16;
    localparam logic [KIND_W-1:0] KIND_LT     = 5'd17;
    localparam logic [KIND_W-1:0] KIND_LE     = 5'd18;
    localparam logic [KIND_W-1:0] KIND_GT     = 5'd19;
    localparam logic [KIND_W-1:0] KIND_GE     = 5'd20;
    localparam logic [KIND_W-1:0] KIND_AND    = 5'd21;
    localparam logic [KIND_W-1:0] KIND_OR     = 5'd22;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd23;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd24;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd25;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd26;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd27;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd28;
    localparam logic [KIND_W-1:0] KIND_END    = 5'd29;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd30;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] line;
        logic [COUNT_W-1:0] column;
        logic [COUNT_W-1:0] length;
        logic               last;
    } slt_token_t;

    // Tokens produced by one character, packed to the front.
    typedef struct packed {
        logic [1:0] count;
        slt_token_t first;
        slt_token_t second;
    } slt_emit_t;

endpackage
`default_nettype wire

@@ rtl/slt_channels.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tokeniser channel interfaces
// Valid/ready channels for source characters and for result tokens.
// ----------------------------------------------------------------------------
interface slt_char_if;
    import slt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface slt_token_if;
    import slt_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  token_kind;
    logic [COUNT_W-1:0] token_line;
    logic [COUNT_W-1:0] token_column;
    logic [COUNT_W-1:0] lexeme_length;
    logic               last_of_run;

    modport source (output valid, output token_kind, output token_line,
                    output token_column, output lexeme_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_line,
                    input token_column, input lexeme_length,
                    input last_of_run, output ready);
endinterface
`default_nettype wire

@@ rtl/small_language_tokenizer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Small language tokeniser
// Character-at-a-time lexer with maximal munch, emitting kind, position and
// lexeme length for each token.
// ----------------------------------------------------------------------------
// The tokeniser takes one source character per clock cycle on the chars
// channel while the queue has room, and delivers tokens, one word per cycle
// while the receiver is ready, on the tokens channel. Each accepted character
// updates the scan mode, the lexeme length and the line and column counters,
// and the tokens it causes are written into a four-word result queue, which
// offers them on the output in order. A character is taken whenever the queue
// has room for two words, which is the most any one character can produce (a
// finished token plus an end marker or a stray character). With the output
// always ready the block sustains one character per cycle; a run of characters
// that each yield two tokens is limited by the single output word per cycle. A
// token carries the line and column of the character that caused it to be
// emitted, and last_of_run marks the final token from that character. Words
// longer than MAX_KEYWORD_LEN characters are always identifiers; lengths and
// counters stick at their maximum. There is no start-up sweep: the block is
// ready as soon as reset is released.
// ----------------------------------------------------------------------------
module small_language_tokenizer_top #(
    parameter int MAX_KEYWORD_LEN = slt_pkg::SLT_MAX_KEYWORD_LEN
) (
    input  logic         clk,
    input  logic         rst_n,
    slt_char_if.sink     chars,
    slt_token_if.source  tokens
);
    import slt_pkg::*;

    logic      room;
    logic      accept;
    slt_emit_t emit;

    assign chars.ready = room;
    assign accept      = chars.valid && room;

    // Scan state and token recognition.
    slt_scan #(
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .char_in (chars.char_in),
        .emit    (emit)
    );

    // Result queue decoupling the output handshake from the scanner.
    slt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (emit),
        .room   (room),
        .tokens (tokens)
    );

endmodule
`default_nettype wire

@@ rtl/slt_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tokeniser scanner
// Scan mode, lexeme state and position counters, updated once per accepted
// character; produces the zero, one or two tokens that character causes.
// ----------------------------------------------------------------------------
module slt_scan #(
    parameter int MAX_KEYWORD_LEN = slt_pkg::SLT_MAX_KEYWORD_LEN
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [slt_pkg::CHAR_W-1:0] char_in,
    output slt_pkg::slt_emit_t         emit
);
    import slt_pkg::*;

    localparam int IDX_W       = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
    localparam int KW_COUNT    = 7;
    localparam int KW_TEXT_MAX = 8;

    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'd34;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'd35;

    localparam logic [CHAR_W-1:0] KW_TEXT [KW_COUNT][KW_TEXT_MAX] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", "c", "t", "i", "o", "n"},
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t", "f", 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd2, 4'd4, 4'd5, 4'd8, 4'd3, 4'd6, 4'd6};

    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_WORD    = 7'b0000010,
        MODE_NUM     = 7'b0000100,
        MODE_STR     = 7'b0001000,
        MODE_STRDONE = 7'b0010000,
        MODE_OPER    = 7'b0100000,
        MODE_PUNCT   = 7'b1000000
    } slt_mode_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + COUNT_W'(1);
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        is_digit = (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_punct(input logic [CHAR_W-1:0] c);
        is_punct = (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                   (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic logic [KIND_W-1:0] oper_kind(input logic [COUNT_W-1:0] len,
                                                   input logic [CHAR_W-1:0]  c0,
                                                   input logic [CHAR_W-1:0]  c1);
        logic [KIND_W-1:0] k;
        k = KIND_ERROR;
        if (len == COUNT_W'(1))
        begin
            unique case (c0)
                "+":     k = KIND_PLUS;
                "-":     k = KIND_MINUS;
                "*":     k = KIND_STAR;
                "/":     k = KIND_SLASH;
                "=":     k = KIND_ASSIGN;
                "<":     k = KIND_LT;
                ">":     k = KIND_GT;
                default: k = KIND_ERROR;
            endcase
        end
        else if (len == COUNT_W'(2))
        begin
            unique case ({c0, c1})
                "==":    k = KIND_EQ;
                "!=":    k = KIND_NE;
                "<=":    k = KIND_LE;
                ">=":    k = KIND_GE;
                "&&":    k = KIND_AND;
                "||":    k = KIND_OR;
                default: k = KIND_ERROR;
            endcase
        end
        oper_kind = k;
    endfunction

    function automatic logic [KIND_W-1:0] punct_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ",":     k = KIND_COMMA;
            ";":     k = KIND_SEMI;
            default: k = KIND_ERROR;
        endcase
        punct_kind = k;
    endfunction

    slt_mode_t          mode_reg, mode_next;
    logic               overlong_reg, overlong_next;
    logic [KIND_W-1:0]  pend_punct_reg, pend_punct_next;
    logic [COUNT_W-1:0] len_reg, len_next;
    logic [COUNT_W-1:0] line_reg, line_next;
    logic [COUNT_W-1:0] col_reg, col_next;
    logic               after_nl_reg, after_nl_next;
    logic [CHAR_W-1:0]  op0_reg, op0_next;
    logic [CHAR_W-1:0]  op1_reg, op1_next;
    logic [CHAR_W-1:0]  word_reg [MAX_KEYWORD_LEN];

    logic               word_we;
    logic [IDX_W-1:0]   word_idx;
    logic [COUNT_W-1:0] line_now;
    logic [COUNT_W-1:0] col_now;
    logic [KIND_W-1:0]  word_kind;
    logic               kw_hit;
    logic               restart;
    logic               e0_valid, e1_valid;
    logic [KIND_W-1:0]  e0_kind, e1_kind;
    logic [COUNT_W-1:0] e0_len;
    slt_token_t         tok0, tok1;

    // Keyword lookup over the kept word characters.
    always_comb
    begin
        word_kind = KIND_IDENT;
        if (!overlong_reg)
        begin
            for (int k = KW_COUNT - 1; k >= 0; k--)
            begin
                kw_hit = (len_reg == COUNT_W'(KW_LEN[k]));
                for (int j = 0; j < KW_TEXT_MAX; j++)
                begin
                    if (j < int'(KW_LEN[k]) && word_reg[j] != KW_TEXT[k][j])
                        kw_hit = 1'b0;
                end
                if (kw_hit)
                    word_kind = KIND_W'(k);
            end
        end
        kw_hit = 1'b0;
    end

    always_comb
    begin
        mode_next       = mode_reg;
        overlong_next   = overlong_reg;
        pend_punct_next = pend_punct_reg;
        len_next        = len_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        after_nl_next   = after_nl_reg;
        op0_next        = op0_reg;
        op1_next        = op1_reg;
        word_we         = 1'b0;
        word_idx        = len_reg[IDX_W-1:0];
        restart         = 1'b0;
        e0_valid        = 1'b0;
        e0_kind         = KIND_ERROR;
        e0_len          = len_reg;
        e1_valid        = 1'b0;
        e1_kind         = KIND_ERROR;

        line_now = after_nl_reg ? sat_inc(line_reg) : line_reg;
        col_now  = after_nl_reg ? COUNT_W'(1) : sat_inc(col_reg);

        if (accept)
        begin
            line_next     = line_now;
            col_next      = col_now;
            after_nl_next = (char_in == CH_NL);

            unique case (mode_reg)
                MODE_WORD:
                begin
                    if (is_alpha(char_in) || is_digit(char_in))
                    begin
                        if (len_reg < COUNT_W'(MAX_KEYWORD_LEN))
                            word_we = 1'b1;
                        else
                            overlong_next = 1'b1;
                        len_next = sat_inc(len_reg);
                    end
                    else
                    begin
                        e0_valid = 1'b1;
                        e0_kind  = word_kind;
                        restart  = 1'b1;
                    end
                end
                MODE_NUM:
                begin
                    if (is_digit(char_in))
                        len_next = sat_inc(len_reg);
                    else
                    begin
                        e0_valid = 1'b1;
                        e0_kind  = KIND_INT;
                        restart  = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    // A newline inside a string counts twice.
                    len_next = after_nl_reg ? sat_inc(sat_inc(len_reg)) : sat_inc(len_reg);
                    if (char_in == CH_QUOTE)
                        mode_next = MODE_STRDONE;
                end
                MODE_STRDONE:
                begin
                    e0_valid = 1'b1;
                    e0_kind  = KIND_STRING;
                    restart  = 1'b1;
                end
                MODE_OPER:
                begin
                    if (is_punct(char_in) && char_in != CH_HASH)
                    begin
                        if (len_reg == COUNT_W'(1))
                            op1_next = char_in;
                        len_next = sat_inc(len_reg);
                    end
                    else
                    begin
                        e0_valid = 1'b1;
                        e0_kind  = oper_kind(len_reg, op0_reg, op1_reg);
                        restart  = 1'b1;
                    end
                end
                MODE_PUNCT:
                begin
                    e0_valid = 1'b1;
                    e0_kind  = pend_punct_reg;
                    e0_len   = COUNT_W'(1);
                    restart  = 1'b1;
                end
                default:
                begin
                    restart = 1'b1;
                end
            endcase

            if (restart)
            begin
                mode_next = MODE_IDLE;
                priority if (is_space(char_in))
                begin
                    mode_next = MODE_IDLE;
                end
                else if (is_alpha(char_in))
                begin
                    mode_next     = MODE_WORD;
                    word_we       = 1'b1;
                    word_idx      = '0;
                    overlong_next = 1'b0;
                    len_next      = COUNT_W'(1);
                end
                else if (is_digit(char_in))
                begin
                    mode_next = MODE_NUM;
                    len_next  = COUNT_W'(1);
                end
                else if (char_in == CH_HASH)
                begin
                    e1_valid = 1'b1;
                    e1_kind  = KIND_END;
                end
                else if (char_in == CH_QUOTE)
                begin
                    mode_next = MODE_STR;
                    len_next  = COUNT_W'(1);
                end
                else if (is_punct(char_in))
                begin
                    len_next = COUNT_W'(1);
                    if (punct_kind(char_in) != KIND_ERROR)
                    begin
                        mode_next       = MODE_PUNCT;
                        pend_punct_next = punct_kind(char_in);
                    end
                    else
                    begin
                        mode_next = MODE_OPER;
                        op0_next  = char_in;
                    end
                end
                else
                begin
                    e1_valid = 1'b1;
                    e1_kind  = KIND_ERROR;
                end
            end
        end
    end

    // Pack the tokens of this character to the front of the group.
    always_comb
    begin
        tok0.kind   = e0_kind;
        tok0.line   = line_now;
        tok0.column = col_now;
        tok0.length = e0_len;
        tok0.last   = !e1_valid;
        tok1.kind   = e1_kind;
        tok1.line   = line_now;
        tok1.column = col_now;
        tok1.length = COUNT_W'(1);
        tok1.last   = 1'b1;

        emit.count  = 2'(e0_valid) + 2'(e1_valid);
        emit.first  = e0_valid ? tok0 : tok1;
        emit.second = tok1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            overlong_reg   <= 1'b0;
            pend_punct_reg <= '0;
            len_reg        <= '0;
            line_reg       <= '0;
            col_reg        <= '0;
            after_nl_reg   <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            overlong_reg   <= overlong_next;
            pend_punct_reg <= pend_punct_next;
            len_reg        <= len_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            after_nl_reg   <= after_nl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op0_reg <= op0_next;
        op1_reg <= op1_next;
        if (word_we)
            word_reg[word_idx] <= char_in;
    end

endmodule
`default_nettype wire

@@ rtl/slt_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tokeniser result queue
// Small queue that takes up to two tokens a cycle and hands out one word a
// cycle on the token channel while its receiver is ready.
// ----------------------------------------------------------------------------
module slt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  slt_pkg::slt_emit_t push,
    output logic               room,
    slt_token_if.source        tokens
);
    import slt_pkg::*;

    localparam int PTR_W = $clog2(SLT_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(SLT_QUEUE_DEPTH + 1);

    slt_token_t         entry_reg [SLT_QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pop;
    slt_token_t         head;

    // Room for two tokens is needed before a character can be taken.
    assign room = (cnt_reg <= CNT_W'(SLT_QUEUE_DEPTH - 2));
    assign pop  = tokens.valid && tokens.ready;
    assign head = entry_reg[rd_ptr_reg];

    assign tokens.valid         = (cnt_reg != '0);
    assign tokens.token_kind    = head.kind;
    assign tokens.token_line    = head.line;
    assign tokens.token_column  = head.column;
    assign tokens.lexeme_length = head.length;
    assign tokens.last_of_run   = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
    end

endmodule
`default_nettype wire
